[hw/rtl/agspo_pkg.sv]
package agspo_pkg;

  localparam int DUTY_BITS   = 14;
  localparam int PWM_FREQ_HZ = 50;

  localparam int CTRL_FULL   = 1000;
  localparam int US_PER_S    = 1000000;
  localparam int SWITCH_LOW  = 600;
  localparam int SWITCH_HIGH = 900;

  localparam int CH_W     = 11;
  localparam int REG_W    = 13;
  localparam int DUTY_W   = 14;
  localparam int CTRL_W   = $clog2(CTRL_FULL + 1);
  localparam int NUM_HELD = 9;
  localparam int NUM_PWM  = 6;
  localparam int CH_IDX_W = $clog2(NUM_PWM);

  localparam int HELD_THROTTLE = 0;
  localparam int HELD_SWITCH   = 6;
  localparam int HELD_DIG_A    = 7;
  localparam int HELD_DIG_B    = 8;

  localparam int PERIOD_RAW = US_PER_S / PWM_FREQ_HZ;
  localparam int PERIOD     = (PERIOD_RAW == 0) ? 1 : PERIOD_RAW;
  localparam int DUTY_FULL  = (1 << DUTY_BITS) - 1;

  // product widths of the two scaling steps
  localparam int P1_W    = CTRL_W + REG_W;
  localparam int P2_W    = REG_W + DUTY_BITS;
  localparam int DVD_W   = (P1_W > P2_W) ? P1_W : P2_W;
  localparam int DIV_MAX = (CTRL_FULL > PERIOD) ? CTRL_FULL : PERIOD;
  localparam int DIV_W   = $clog2(DIV_MAX);
  localparam int CNT_W   = $clog2(DVD_W);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = CFG_IDX_W'(1);

  localparam logic [REG_W-1:0] PULSE_MIN_RST = REG_W'(500);
  localparam logic [REG_W-1:0] PULSE_MAX_RST = REG_W'(2400);

  typedef enum logic [1:0] {
    MODE_UPDATE   = 2'd0,
    MODE_ARM      = 2'd1,
    MODE_DISARM   = 2'd2,
    MODE_FAILSAFE = 2'd3
  } mode_t;

  typedef struct packed {
    logic             start;
    logic [CH_W-1:0]  ctrl;
    logic [REG_W-1:0] pmin;
    logic [REG_W-1:0] span;
  } chan_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] duty;
  } chan_rsp_t;

endpackage

[hw/rtl/agspo_chan.sv]
module agspo_chan (
  input  logic                clk,
  input  logic                rst_n,
  input  agspo_pkg::chan_req_t req,
  output agspo_pkg::chan_rsp_t rsp
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_LOAD,
    U_DIV,
    U_SCALE,
    U_SAT
  } ustate_t;

  ustate_t st_r, st_nxt;
  logic [agspo_pkg::P1_W-1:0]   acc_r, acc_nxt;
  logic [agspo_pkg::P1_W-1:0]   mcand_r, mcand_nxt;
  logic [agspo_pkg::CTRL_W-1:0] mpl_r, mpl_nxt;
  logic [agspo_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [agspo_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [agspo_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [agspo_pkg::REG_W-1:0]  pmin_r, pmin_nxt;
  logic                         ph_r, ph_nxt;
  logic                         done_r, done_nxt;
  logic [agspo_pkg::DUTY_W-1:0] duty_r, duty_nxt;

  logic [agspo_pkg::CTRL_W-1:0] clamp;
  logic [agspo_pkg::DIV_W:0]    shifted;
  logic [agspo_pkg::DIV_W:0]    divisor;
  logic                         ge;
  logic [agspo_pkg::REG_W-1:0]  us;
  logic [agspo_pkg::P2_W-1:0]   prod;

  assign clamp = (req.ctrl > agspo_pkg::CH_W'(agspo_pkg::CTRL_FULL))
               ? agspo_pkg::CTRL_W'(agspo_pkg::CTRL_FULL)
               : req.ctrl[agspo_pkg::CTRL_W-1:0];

  // one restoring division step, quotient bit shifts into the dividend
  assign shifted = {rem_r, dvd_r[agspo_pkg::DVD_W-1]};
  assign divisor = ph_r ? (agspo_pkg::DIV_W+1)'(agspo_pkg::PERIOD)
                        : (agspo_pkg::DIV_W+1)'(agspo_pkg::CTRL_FULL);
  assign ge      = (shifted >= divisor);

  // pulse width never exceeds the larger pulse-width register, so 13 bits hold it
  assign us   = dvd_r[agspo_pkg::REG_W-1:0] + pmin_r;
  assign prod = (agspo_pkg::P2_W'(us) << agspo_pkg::DUTY_BITS) - agspo_pkg::P2_W'(us);

  always_comb begin
    st_nxt    = st_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mpl_nxt   = mpl_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    pmin_nxt  = pmin_r;
    ph_nxt    = ph_r;
    done_nxt  = 1'b0;
    duty_nxt  = duty_r;
    unique case (st_r)
      U_IDLE: begin
        if (req.start) begin
          acc_nxt   = '0;
          mcand_nxt = agspo_pkg::P1_W'(req.span);
          mpl_nxt   = clamp;
          pmin_nxt  = req.pmin;
          cnt_nxt   = '0;
          st_nxt    = U_MUL;
        end
      end
      U_MUL: begin
        if (mpl_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = mcand_r << 1;
        mpl_nxt   = mpl_r >> 1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == agspo_pkg::CNT_W'(agspo_pkg::CTRL_W - 1)) begin
          st_nxt = U_LOAD;
        end
      end
      U_LOAD: begin
        dvd_nxt = agspo_pkg::DVD_W'(acc_r);
        rem_nxt = '0;
        cnt_nxt = '0;
        ph_nxt  = 1'b0;
        st_nxt  = U_DIV;
      end
      U_DIV: begin
        rem_nxt = ge ? agspo_pkg::DIV_W'(shifted - divisor) : agspo_pkg::DIV_W'(shifted);
        dvd_nxt = {dvd_r[agspo_pkg::DVD_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == agspo_pkg::CNT_W'(agspo_pkg::DVD_W - 1)) begin
          st_nxt = ph_r ? U_SAT : U_SCALE;
        end
      end
      U_SCALE: begin
        dvd_nxt = agspo_pkg::DVD_W'(prod);
        rem_nxt = '0;
        cnt_nxt = '0;
        ph_nxt  = 1'b1;
        st_nxt  = U_DIV;
      end
      U_SAT: begin
        if (dvd_r > agspo_pkg::DVD_W'(agspo_pkg::DUTY_FULL)) begin
          duty_nxt = agspo_pkg::DUTY_W'(agspo_pkg::DUTY_FULL);
        end else begin
          duty_nxt = dvd_r[agspo_pkg::DUTY_W-1:0];
        end
        done_nxt = 1'b1;
        st_nxt   = U_IDLE;
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mpl_r   <= mpl_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    pmin_r  <= pmin_nxt;
    duty_r  <= duty_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.duty = duty_r;

endmodule

[hw/rtl/arm_gated_servo_pwm_output.sv]
// arm-gated servo pwm output
// input channel (in_valid/in_ready): one event per request, in_mode selects
// update (all nine channel fields stored), arm, disarm or failsafe.
// result channel (out_valid/out_ready): six duty counts, two digital pins
// and the armed flag after the event. an arm request while already armed
// is absorbed in its accept cycle and gives no result.
// config channel (cfg_valid/cfg_ready): always ready, index 0 is the
// minimum pulse width, index 1 the maximum, other indexes are ignored.
// timing: the six duties go one after another through a shared bit-serial
// unit (shift-add multiply, two restoring divides by constants), channel
// by channel. in_ready is high only while no event is in work; one event
// at a time, so no new request is taken before the previous one is
// finished.
// the finished result sits in an output register; if the receiver stalls,
// the block can take the next request and only waits at the end of it
// until the previous result is taken.
// reset: disarmed, throttle cut set, other flags clear, held channels
// zero, pulse widths 500 and 2400 us, no result pending.
module arm_gated_servo_pwm_output (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_mode,
  input  logic [agspo_pkg::CH_W-1:0]            in_throttle,
  input  logic [agspo_pkg::CH_W-1:0]            in_roll,
  input  logic [agspo_pkg::CH_W-1:0]            in_pitch,
  input  logic [agspo_pkg::CH_W-1:0]            in_yaw,
  input  logic [agspo_pkg::CH_W-1:0]            in_aux_pwm_a,
  input  logic [agspo_pkg::CH_W-1:0]            in_aux_pwm_b,
  input  logic [agspo_pkg::CH_W-1:0]            in_arm_switch,
  input  logic [agspo_pkg::CH_W-1:0]            in_digital_a,
  input  logic [agspo_pkg::CH_W-1:0]            in_digital_b,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [agspo_pkg::DUTY_W-1:0]          out_duty_throttle,
  output logic [agspo_pkg::DUTY_W-1:0]          out_duty_roll,
  output logic [agspo_pkg::DUTY_W-1:0]          out_duty_pitch,
  output logic [agspo_pkg::DUTY_W-1:0]          out_duty_yaw,
  output logic [agspo_pkg::DUTY_W-1:0]          out_duty_aux_a,
  output logic [agspo_pkg::DUTY_W-1:0]          out_duty_aux_b,
  output logic                                  out_pin_one,
  output logic                                  out_pin_two,
  output logic                                  out_is_armed,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [agspo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [agspo_pkg::REG_W-1:0]           cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_OUT
  } state_t;

  state_t st_r, st_nxt;
  logic [agspo_pkg::CH_IDX_W-1:0] idx_r, idx_nxt;
  logic armed_r, armed_nxt;
  logic sw_rdy_r, sw_rdy_nxt;
  logic fs_r, fs_nxt;
  logic cut_r, cut_nxt;
  logic [agspo_pkg::CH_W-1:0]   held_r [agspo_pkg::NUM_HELD];
  logic [agspo_pkg::CH_W-1:0]   held_nxt [agspo_pkg::NUM_HELD];
  logic [agspo_pkg::DUTY_W-1:0] dw_r [agspo_pkg::NUM_PWM];
  logic [agspo_pkg::DUTY_W-1:0] dw_nxt [agspo_pkg::NUM_PWM];
  logic [agspo_pkg::REG_W-1:0]  pmin_r, pmin_nxt;
  logic [agspo_pkg::REG_W-1:0]  pmax_r, pmax_nxt;
  logic                         ov_r, ov_nxt;
  logic [agspo_pkg::DUTY_W-1:0] od_r [agspo_pkg::NUM_PWM];
  logic [agspo_pkg::DUTY_W-1:0] od_nxt [agspo_pkg::NUM_PWM];
  logic pin1_r, pin1_nxt;
  logic pin2_r, pin2_nxt;
  logic oarm_r, oarm_nxt;

  logic                         skip;
  logic                         ev_armed;
  logic                         ev_fs;
  logic [agspo_pkg::CH_W-1:0]   sw_v;
  logic [agspo_pkg::CH_W-1:0]   thr_v;
  logic [agspo_pkg::CH_W-1:0]   in_ch [agspo_pkg::NUM_HELD];
  logic [agspo_pkg::CH_W-1:0]   pwm_v [agspo_pkg::NUM_PWM];
  logic [agspo_pkg::REG_W-1:0]  span;

  agspo_pkg::chan_req_t req;
  agspo_pkg::chan_rsp_t rsp;

  assign in_ch[0] = in_throttle;
  assign in_ch[1] = in_roll;
  assign in_ch[2] = in_pitch;
  assign in_ch[3] = in_yaw;
  assign in_ch[4] = in_aux_pwm_a;
  assign in_ch[5] = in_aux_pwm_b;
  assign in_ch[6] = in_arm_switch;
  assign in_ch[7] = in_digital_a;
  assign in_ch[8] = in_digital_b;

  for (genvar g = 0; g < agspo_pkg::NUM_PWM; g++) begin : g_pwm
    if (g == agspo_pkg::HELD_THROTTLE) begin : g_thr
      assign pwm_v[g] = cut_r ? '0 : held_r[g];
    end else begin : g_other
      assign pwm_v[g] = held_r[g];
    end
  end

  assign span = (pmax_r >= pmin_r) ? (pmax_r - pmin_r) : '0;

  assign req.start = (st_r == ST_START);
  assign req.ctrl  = pwm_v[idx_r];
  assign req.pmin  = pmin_r;
  assign req.span  = span;

  agspo_chan u_chan (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    armed_nxt  = armed_r;
    sw_rdy_nxt = sw_rdy_r;
    fs_nxt     = fs_r;
    cut_nxt    = cut_r;
    held_nxt   = held_r;
    dw_nxt     = dw_r;
    pmin_nxt   = pmin_r;
    pmax_nxt   = pmax_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    pin1_nxt   = pin1_r;
    pin2_nxt   = pin2_r;
    oarm_nxt   = oarm_r;
    skip       = 1'b0;
    ev_armed   = armed_r;
    ev_fs      = fs_r;
    sw_v       = held_r[agspo_pkg::HELD_SWITCH];
    thr_v      = held_r[agspo_pkg::HELD_THROTTLE];

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        agspo_pkg::CFG_PULSE_MIN: pmin_nxt = cfg_data;
        agspo_pkg::CFG_PULSE_MAX: pmax_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (agspo_pkg::mode_t'(in_mode))
            agspo_pkg::MODE_UPDATE: begin
              ev_fs    = 1'b0;
              held_nxt = in_ch;
              sw_v     = in_arm_switch;
              thr_v    = in_throttle;
            end
            agspo_pkg::MODE_ARM: begin
              if (armed_r) begin
                skip = 1'b1;
              end else begin
                ev_armed = 1'b1;
                ev_fs    = 1'b0;
              end
            end
            agspo_pkg::MODE_DISARM: begin
              ev_armed = 1'b0;
            end
            agspo_pkg::MODE_FAILSAFE: begin
              ev_fs    = 1'b1;
              ev_armed = 1'b0;
            end
            default: ;
          endcase
          if (!skip) begin
            // switch rule on the channels held after this event
            if (sw_v <= agspo_pkg::CH_W'(agspo_pkg::SWITCH_LOW)) begin
              sw_rdy_nxt = 1'b1;
              ev_armed   = 1'b0;
            end else if (sw_rdy_r && !ev_armed &&
                         sw_v >= agspo_pkg::CH_W'(agspo_pkg::SWITCH_HIGH) &&
                         thr_v == '0) begin
              ev_armed = 1'b1;
            end
            armed_nxt = ev_armed;
            fs_nxt    = ev_fs;
            cut_nxt   = !ev_armed || ev_fs;
            idx_nxt   = '0;
            st_nxt    = ST_START;
          end
        end
      end
      ST_START: begin
        st_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp.done) begin
          dw_nxt[idx_r] = rsp.duty;
          if (idx_r == agspo_pkg::CH_IDX_W'(agspo_pkg::NUM_PWM - 1)) begin
            st_nxt = ST_OUT;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = ST_START;
          end
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          od_nxt   = dw_r;
          pin1_nxt = (held_r[agspo_pkg::HELD_DIG_A] != '0);
          pin2_nxt = (held_r[agspo_pkg::HELD_DIG_B] != '0);
          oarm_nxt = armed_r;
          ov_nxt   = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      idx_r    <= '0;
      armed_r  <= 1'b0;
      sw_rdy_r <= 1'b0;
      fs_r     <= 1'b0;
      cut_r    <= 1'b1;
      ov_r     <= 1'b0;
      pmin_r   <= agspo_pkg::PULSE_MIN_RST;
      pmax_r   <= agspo_pkg::PULSE_MAX_RST;
      for (int i = 0; i < agspo_pkg::NUM_HELD; i++) begin
        held_r[i] <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      idx_r    <= idx_nxt;
      armed_r  <= armed_nxt;
      sw_rdy_r <= sw_rdy_nxt;
      fs_r     <= fs_nxt;
      cut_r    <= cut_nxt;
      ov_r     <= ov_nxt;
      pmin_r   <= pmin_nxt;
      pmax_r   <= pmax_nxt;
      held_r   <= held_nxt;
    end
    dw_r   <= dw_nxt;
    od_r   <= od_nxt;
    pin1_r <= pin1_nxt;
    pin2_r <= pin2_nxt;
    oarm_r <= oarm_nxt;
  end

  assign in_ready          = (st_r == ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = ov_r;
  assign out_duty_throttle = od_r[0];
  assign out_duty_roll     = od_r[1];
  assign out_duty_pitch    = od_r[2];
  assign out_duty_yaw      = od_r[3];
  assign out_duty_aux_a    = od_r[4];
  assign out_duty_aux_b    = od_r[5];
  assign out_pin_one       = pin1_r;
  assign out_pin_two       = pin2_r;
  assign out_is_armed      = oarm_r;

endmodule

[hw/rtl/agspo_checker.sv]
module agspo_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [1:0]                      in_mode,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [agspo_pkg::DUTY_W-1:0]    out_duty_throttle,
  input logic [agspo_pkg::DUTY_W-1:0]    out_duty_roll,
  input logic                            out_is_armed,
  input logic                            cfg_ready
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_throttle) &&
                                $stable(out_duty_roll) && $stable(out_is_armed))
    else $error("stalled result changed");

  // a request other than arm always gives a result and closes the input once accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode != agspo_pkg::MODE_ARM |=> !in_ready)
    else $error("input reopened while an event is in work");

  // a new result only appears at the end of an event
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an event in work");

  // reset leaves no result pending and config open
  assert property (@(posedge clk)
    !rst_n |=> !out_valid && cfg_ready)
    else $error("bad state after reset");

endmodule

bind arm_gated_servo_pwm_output agspo_checker u_agspo_checker (.*);
